// ----- hw/rtl/qved_pkg.sv -----
// Shared types and constants for the query value extract and decode block.
`default_nettype none

package qved_pkg;

  // Longest key the matcher compares; longer key_length values are clamped to it.
  localparam int KEY_MAX_BYTES = 16;

  // Most results one input byte can produce: two flushed bytes, one byte and the end result.
  localparam int MAX_RES = 4;

  // Default depth of the result queue.
  localparam int RESQ_DEPTH_DEF = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_PERCENT = 8'd37;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_EQUALS  = 8'd61;
  localparam logic [7:0] CH_AMP     = 8'd38;
  localparam logic [7:0] CH_QMARK   = 8'd63;

  typedef enum logic [2:0] {
    PH_BEGIN = 3'd0,
    PH_KEY   = 3'd1,
    PH_EQ    = 3'd2,
    PH_VALUE = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  match_index;
    logic        at_first;
    logic [1:0]  esc;
    logic [7:0]  held;
    logic        any_emitted;
  } qved_state_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       value_found;
  } qved_res_t;

  localparam qved_state_t STATE_RESET = '{
    phase:       PH_BEGIN,
    match_index: 5'd0,
    at_first:    1'b1,
    esc:         2'd0,
    held:        8'd0,
    any_emitted: 1'b0
  };

endpackage

`default_nettype wire

// ----- hw/rtl/qved_step.sv -----
// Per-byte parser step: key match, percent decode and result generation.
`default_nettype none

module qved_step
  import qved_pkg::*;
(
  input  qved_state_t               st,
  input  logic [7:0]                query_byte,
  input  logic                      last_byte,
  input  logic [63:0]               key_low,
  input  logic [63:0]               key_high,
  input  logic [4:0]                key_length,
  output qved_state_t               st_nxt,
  output qved_res_t [MAX_RES-1:0]   res,
  output logic [2:0]                res_cnt
);

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd70) ||
           (b >= 8'd97 && b <= 8'd102);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] u;
    logic [7:0] d;
    u = (b >= 8'd97) ? (b - 8'd32) : b;
    d = (u >= 8'd65) ? (u - 8'd55) : (u - 8'd48);
    return d[3:0];
  endfunction

  function automatic qved_res_t mk_byte(input logic [7:0] b);
    return '{value_byte: b, byte_valid: 1'b1, end_of_string: 1'b0, value_found: 1'b0};
  endfunction

  logic [127:0] key_all;
  logic [7:0]   key_sel;
  logic [4:0]   eff_len;
  logic [4:0]   mi_in;
  logic [4:0]   mi_inc;

  assign key_all = {key_high, key_low};
  assign mi_in   = st.at_first ? 5'd0 : st.match_index;
  assign mi_inc  = mi_in + 5'd1;
  assign key_sel = key_all[{mi_in[3:0], 3'b000} +: 8];

  always_comb begin
    if (key_length == 5'd0) begin
      eff_len = 5'd1;
    end else if (key_length > 5'(KEY_MAX_BYTES)) begin
      eff_len = 5'(KEY_MAX_BYTES);
    end else begin
      eff_len = key_length;
    end
  end

  always_comb begin
    phase_t     ph;
    phase_t     ph_w;
    logic [4:0] mi_w;
    logic [1:0] esc_w;
    logic [7:0] held_w;
    logic       any_w;
    logic [2:0] n;
    logic       hexb;

    ph     = st.at_first ? PH_KEY : st.phase;
    ph_w   = ph;
    mi_w   = mi_in;
    esc_w  = st.esc;
    held_w = st.held;
    any_w  = st.any_emitted;
    n      = 3'd0;
    hexb   = is_hex(query_byte);
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end

    unique case (ph)
      PH_BEGIN: begin
        mi_w = 5'd0;
        if (query_byte == CH_EQUALS || query_byte == CH_AMP || query_byte == CH_QMARK) begin
          ph_w = PH_KEY;
        end
      end
      PH_KEY: begin
        if (query_byte == CH_EQUALS || query_byte == CH_AMP) begin
          mi_w = 5'd0;
        end else if (query_byte != key_sel) begin
          mi_w = 5'd0;
          ph_w = PH_BEGIN;
        end else begin
          mi_w = mi_inc;
          if (mi_inc >= eff_len) begin
            ph_w = PH_EQ;
          end
        end
      end
      PH_EQ: begin
        if (query_byte == CH_EQUALS) begin
          ph_w  = PH_VALUE;
          esc_w = 2'd0;
        end else begin
          ph_w = PH_BEGIN;
        end
        mi_w = 5'd0;
      end
      PH_VALUE: begin
        if (query_byte == CH_AMP) begin
          // pending escape is written out literally
          if (esc_w == 2'd1 || esc_w == 2'd2) begin
            res[n[1:0]] = mk_byte(CH_PERCENT);
            n = n + 3'd1;
            any_w = 1'b1;
          end
          if (esc_w == 2'd2) begin
            res[n[1:0]] = mk_byte(held_w);
            n = n + 3'd1;
          end
          esc_w = 2'd0;
          ph_w  = PH_DONE;
        end else if (esc_w == 2'd1 && hexb) begin
          held_w = query_byte;
          esc_w  = 2'd2;
        end else if (esc_w == 2'd2 && hexb) begin
          esc_w = 2'd0;
          res[n[1:0]] = mk_byte({hex_val(held_w), hex_val(query_byte)});
          n = n + 3'd1;
          any_w = 1'b1;
        end else begin
          // broken escape: flush it, then take this byte afresh
          if (esc_w == 2'd1 || esc_w == 2'd2) begin
            res[n[1:0]] = mk_byte(CH_PERCENT);
            n = n + 3'd1;
            any_w = 1'b1;
          end
          if (esc_w == 2'd2) begin
            res[n[1:0]] = mk_byte(held_w);
            n = n + 3'd1;
          end
          esc_w = 2'd0;
          if (query_byte == CH_PERCENT) begin
            esc_w = 2'd1;
          end else if (query_byte == CH_PLUS) begin
            res[n[1:0]] = mk_byte(CH_SPACE);
            n = n + 3'd1;
            any_w = 1'b1;
          end else begin
            res[n[1:0]] = mk_byte(query_byte);
            n = n + 3'd1;
            any_w = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (ph_w == PH_VALUE) begin
        if (esc_w == 2'd1 || esc_w == 2'd2) begin
          res[n[1:0]] = mk_byte(CH_PERCENT);
          n = n + 3'd1;
          any_w = 1'b1;
        end
        if (esc_w == 2'd2) begin
          res[n[1:0]] = mk_byte(held_w);
          n = n + 3'd1;
        end
      end
      res[n[1:0]] = '{value_byte: 8'd0, byte_valid: 1'b0, end_of_string: 1'b1,
                      value_found: any_w};
      n = n + 3'd1;
      st_nxt = STATE_RESET;
    end else begin
      st_nxt = '{phase: ph_w, match_index: mi_w, at_first: 1'b0, esc: esc_w,
                 held: held_w, any_emitted: any_w};
    end
    res_cnt = n;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/qved_resq.sv -----
// Result queue: takes up to four results per cycle, hands out one per cycle unless out_stall.
`default_nettype none

module qved_resq
  import qved_pkg::*;
#(
  parameter int DEPTH = RESQ_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_en,
  input  logic [2:0]              push_cnt,
  input  qved_res_t [MAX_RES-1:0] push_data,
  output logic                    no_room,
  output logic                    out_valid,
  output qved_res_t               out_data,
  input  logic                    out_stall
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qved_res_t         mem [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [2:0]        n_push;
  logic              pop;
  logic [PW-1:0]     slot [MAX_RES];

  assign n_push    = push_en ? push_cnt : 3'd0;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // stall input unless a worst-case burst fits
  assign no_room   = (count_r > CW'(DEPTH - MAX_RES));

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [2:0] k);
    logic [PW+2:0] s;
    s = (PW + 3)'(p) + (PW + 3)'(k);
    if (s >= (PW + 3)'(DEPTH)) begin
      s = s - (PW + 3)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      slot[k] = wrap_add(wr_ptr_r, 3'(k));
    end
    wr_ptr_nxt = wrap_add(wr_ptr_r, n_push);
    rd_ptr_nxt = pop ? wrap_add(rd_ptr_r, 3'd1) : rd_ptr_r;
    count_nxt  = count_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (3'(k) < n_push) begin
        mem[slot[k]] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/query_value_extract_decode_core.sv -----
// Top level: configuration registers, parser state and result queue.
// Results: the results of a byte enter the queue at its acceptance edge and are offered
//   on out_* in order behind results already waiting, one per cycle unless out_stall.
// Throughput: one byte per cycle while the queue can absorb a four-result burst; the
//   queue drains one result per cycle unless stalled; in_stall: over DEPTH-4 waiting.
// Reset (synchronous, rst_n low): stream state to start of string, key registers to
//   zero, key length to one, queue emptied. No clearing pass.
`default_nettype none

module query_value_extract_decode_core
  import qved_pkg::*;
#(
  parameter int RESQ_DEPTH = RESQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_query_byte,
  input  logic        in_last_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_value_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_string,
  output logic        out_value_found,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0]             key_low_r;
  logic [63:0]             key_high_r;
  logic [4:0]              key_len_r;
  qved_state_t             st_r, st_nxt;
  qved_res_t [MAX_RES-1:0] step_res;
  logic [2:0]              step_cnt;
  qved_res_t               head;
  logic                    in_accept;

  assign in_accept = in_valid && !in_stall;

  // Key registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LEN:  key_len_r  <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  qved_step u_step (
    .st         (st_r),
    .query_byte (in_query_byte),
    .last_byte  (in_last_byte),
    .key_low    (key_low_r),
    .key_high   (key_high_r),
    .key_length (key_len_r),
    .st_nxt     (st_nxt),
    .res        (step_res),
    .res_cnt    (step_cnt)
  );

  // Parser state only moves when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  qved_resq #(
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_accept),
    .push_cnt  (step_cnt),
    .push_data (step_res),
    .no_room   (in_stall),
    .out_valid (out_valid),
    .out_data  (head),
    .out_stall (out_stall)
  );

  assign out_value_byte    = head.value_byte;
  assign out_byte_valid    = head.byte_valid;
  assign out_end_of_string = head.end_of_string;
  assign out_value_found   = head.value_found;

endmodule

`default_nettype wire
